// File: sv/smeb_pkg.sv
// ----------------------------------------------------------------------------
// smeb_pkg
// Shared types and constants for the stepper move controller with endstop
// back-off: operation codes, register map, field widths and the
// command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package smeb_pkg;

  // Operation codes carried in s_tuser
  localparam logic OP_START = 1'b0;
  localparam logic OP_TICK  = 1'b1;

  // Register indexes, byte address = 4 * index
  localparam logic [1:0] REG_STEP_ANGLE    = 2'd0;
  localparam logic [1:0] REG_BACKOFF_STEPS = 2'd1;
  localparam logic [1:0] REG_HALF_PERIOD   = 2'd2;
  localparam logic [1:0] REG_DIR_INVERT    = 2'd3;

  // Register reset values
  localparam logic [15:0] RST_STEP_ANGLE    = 16'd461;
  localparam logic [15:0] RST_BACKOFF_STEPS = 16'd16;
  localparam logic [15:0] RST_HALF_PERIOD   = 16'd1;
  localparam logic        RST_DIR_INVERT    = 1'b0;

  // Field and bus widths
  localparam int ANGLE_W   = 20;
  localparam int CFG_W     = 16;
  localparam int S_TDATA_W = 24;
  localparam int M_TDATA_W = 8;
  localparam int PADDR_W   = 4;
  localparam int PDATA_W   = 32;

  // Bit positions in the packed buses
  localparam int S_ENDSTOP_BIT = 20;
  localparam int M_STEP_BIT    = 0;
  localparam int M_DIR_BIT     = 1;
  localparam int M_BUSY_BIT    = 2;
  localparam int M_HIT_BIT     = 3;

  // Configuration values seen by the datapath
  typedef struct packed {
    logic [CFG_W-1:0] step_angle;
    logic [CFG_W-1:0] backoff_steps;
    logic [CFG_W-1:0] half_period;
    logic             direction_invert;
  } cfg_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic tick;      // apply one tick and write a result
    logic report;    // start while busy: write unchanged levels
    logic div_load;  // load the step count divider
    logic div_step;  // one quotient bit
    logic commit;    // load the move from the quotient and write a result
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic busy;      // a move is in progress
    logic div_last;  // divider is on its final bit
    logic out_free;  // output register can take a result this cycle
  } sts_t;

endpackage

// File: sv/smeb_regs.sv
// ----------------------------------------------------------------------------
// smeb_regs
// APB register file holding step angle, back-off count, half period and the
// direction invert bit.
// ----------------------------------------------------------------------------
module smeb_regs (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [smeb_pkg::PADDR_W-1:0]   paddr,
  input  logic [smeb_pkg::PDATA_W-1:0]   pwdata,
  output logic [smeb_pkg::PDATA_W-1:0]   prdata,
  output logic                           pready,
  output smeb_pkg::cfg_t                 cfg
);
  import smeb_pkg::*;

  logic          wr_en;
  logic [1:0]    reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_idx = paddr[3:2];

  // Write the addressed register
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.step_angle       <= RST_STEP_ANGLE;
      cfg.backoff_steps    <= RST_BACKOFF_STEPS;
      cfg.half_period      <= RST_HALF_PERIOD;
      cfg.direction_invert <= RST_DIR_INVERT;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_STEP_ANGLE:    cfg.step_angle       <= pwdata[CFG_W-1:0];
        REG_BACKOFF_STEPS: cfg.backoff_steps    <= pwdata[CFG_W-1:0];
        REG_HALF_PERIOD:   cfg.half_period      <= pwdata[CFG_W-1:0];
        REG_DIR_INVERT:    cfg.direction_invert <= pwdata[0];
        default: ;
      endcase
    end
  end

  // Read back the addressed register
  always_comb begin
    unique case (reg_idx)
      REG_STEP_ANGLE:    prdata = PDATA_W'(cfg.step_angle);
      REG_BACKOFF_STEPS: prdata = PDATA_W'(cfg.backoff_steps);
      REG_HALF_PERIOD:   prdata = PDATA_W'(cfg.half_period);
      REG_DIR_INVERT:    prdata = PDATA_W'(cfg.direction_invert);
      default:           prdata = '0;
    endcase
  end

endmodule

// File: sv/smeb_ctrl.sv
// ----------------------------------------------------------------------------
// smeb_ctrl
// Sequencer: accepts one item at a time, runs the step count division for
// a start command and tells the datapath when to update and report.
// ----------------------------------------------------------------------------
module smeb_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           s_tvalid,
  output logic           s_tready,
  input  logic           op,
  input  smeb_pkg::sts_t sts,
  output smeb_pkg::cmd_t cmd
);
  import smeb_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_COMMIT
  } state_t;

  state_t state;
  state_t state_next;
  logic   accept;

  assign s_tready = (state == S_IDLE) && sts.out_free;
  assign accept   = s_tvalid && s_tready;

  // Decode commands and next state
  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          if (op == OP_TICK) begin
            cmd.tick = 1'b1;
          end else if (sts.busy) begin
            cmd.report = 1'b1;
          end else begin
            cmd.div_load = 1'b1;
            state_next   = S_DIV;
          end
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) state_next = S_COMMIT;
      end
      S_COMMIT: begin
        cmd.commit = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Hold state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Division always runs into a commit
  a_div_commit: assert property (@(posedge clk) disable iff (rst)
    state == S_DIV && sts.div_last |=> state == S_COMMIT)
    else $error("divider end not followed by commit");

  // A start on an idle axis always enters the divider
  a_start_div: assert property (@(posedge clk) disable iff (rst)
    accept && op == OP_START && !sts.busy |=> state == S_DIV)
    else $error("start on idle axis did not divide");

  // No command while an item is in division
  a_div_quiet: assert property (@(posedge clk) disable iff (rst)
    state == S_DIV |-> !cmd.tick && !cmd.report && !cmd.commit)
    else $error("stray command during division");

endmodule

// File: sv/smeb_dp.sv
// ----------------------------------------------------------------------------
// smeb_dp
// Datapath: restoring divider for the step count, motion state (step phase,
// tick counter, remaining steps, back-off) and the output register.
// ----------------------------------------------------------------------------
module smeb_dp #(
  parameter int ANGLE_BITS = 20
) (
  input  logic                            clk,
  input  logic                            rst,
  input  smeb_pkg::cmd_t                  cmd,
  output smeb_pkg::sts_t                  sts,
  input  smeb_pkg::cfg_t                  cfg,
  input  logic [smeb_pkg::ANGLE_W-1:0]    angle,
  input  logic                            endstop,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [smeb_pkg::M_TDATA_W-1:0]  m_tdata,
  output logic                            m_tlast
);
  import smeb_pkg::*;

  localparam int          CNT_W   = $clog2(ANGLE_BITS + 1);
  localparam logic [32:0] CNT_MAX = (33'd1 << ANGLE_BITS) - 33'd1;

  // Motion state
  logic                  busy_flag,   busy_flag_next;
  logic                  backing_off, backing_off_next;
  logic                  direction,   direction_next;
  logic [ANGLE_BITS-1:0] steps_left,  steps_left_next;
  logic [CFG_W-1:0]      tick_count,  tick_count_next;
  logic                  pulse_high,  pulse_high_next;

  // Divider
  logic [ANGLE_BITS-1:0] dvd;
  logic [CFG_W-1:0]      rem;
  logic [CFG_W-1:0]      dsr;
  logic [CNT_W-1:0]      div_cnt;
  logic [CFG_W:0]        trial;
  logic [CFG_W:0]        diff;
  logic                  ge;

  // Result
  logic                  out_wr;
  logic                  done_next;
  logic                  hit_next;
  logic                  complete;
  logic                  out_step, out_dir, out_busy, out_done, out_hit;

  logic [CFG_W-1:0]      phase_m1;
  logic [32:0]           bo_wide;
  logic [ANGLE_BITS-1:0] bo_sat;

  assign sts.busy     = busy_flag;
  assign sts.div_last = (div_cnt == CNT_W'(1));
  assign sts.out_free = !m_tvalid || m_tready;

  // One restoring divide step
  assign trial = {rem, dvd[ANGLE_BITS-1]};
  assign diff  = trial - {1'b0, dsr};
  assign ge    = (trial >= {1'b0, dsr});

  always_ff @(posedge clk) begin
    if (rst) begin
      div_cnt <= '0;
    end else if (cmd.div_load) begin
      dvd     <= ANGLE_BITS'(angle);
      rem     <= '0;
      dsr     <= (cfg.step_angle == '0) ? CFG_W'(1) : cfg.step_angle;
      div_cnt <= CNT_W'(ANGLE_BITS);
    end else if (cmd.div_step) begin
      dvd     <= {dvd[ANGLE_BITS-2:0], ge};
      rem     <= ge ? diff[CFG_W-1:0] : trial[CFG_W-1:0];
      div_cnt <= div_cnt - CNT_W'(1);
    end
  end

  // Phase length and saturated back-off count
  assign phase_m1 = (cfg.half_period == '0) ? '0 : cfg.half_period - CFG_W'(1);
  assign bo_wide  = 33'(cfg.backoff_steps);
  assign bo_sat   = (bo_wide > CNT_MAX) ? '1 : ANGLE_BITS'(cfg.backoff_steps);

  // Next motion state for tick, report and commit
  always_comb begin
    busy_flag_next   = busy_flag;
    backing_off_next = backing_off;
    direction_next   = direction;
    steps_left_next  = steps_left;
    tick_count_next  = tick_count;
    pulse_high_next  = pulse_high;
    done_next        = 1'b0;
    hit_next         = 1'b0;
    out_wr           = 1'b0;
    complete         = 1'b0;
    if (cmd.tick) begin
      out_wr = 1'b1;
      if (busy_flag) begin
        if (!pulse_high && tick_count == '0) begin
          // start of a step: sample the endstop
          if (!backing_off && endstop) begin
            backing_off_next = 1'b1;
            direction_next   = ~direction;
            steps_left_next  = bo_sat;
            if (bo_sat == '0) begin
              busy_flag_next   = 1'b0;
              done_next        = 1'b1;
              hit_next         = 1'b1;
              backing_off_next = 1'b0;
            end else begin
              pulse_high_next = 1'b1;
              tick_count_next = phase_m1;
            end
          end else begin
            pulse_high_next = 1'b1;
            tick_count_next = phase_m1;
          end
        end else if (pulse_high) begin
          if (tick_count != '0) begin
            tick_count_next = tick_count - CFG_W'(1);
          end else begin
            pulse_high_next = 1'b0;
            tick_count_next = phase_m1;
            complete        = (phase_m1 == '0);
          end
        end else begin
          tick_count_next = tick_count - CFG_W'(1);
          complete        = (tick_count == CFG_W'(1));
        end
        // close the step and end the move on the last one
        if (complete) begin
          steps_left_next = steps_left - ANGLE_BITS'(1);
          if (steps_left == ANGLE_BITS'(1)) begin
            busy_flag_next   = 1'b0;
            done_next        = 1'b1;
            hit_next         = backing_off;
            backing_off_next = 1'b0;
          end
        end
      end
    end else if (cmd.report) begin
      out_wr = 1'b1;
    end else if (cmd.commit) begin
      out_wr           = 1'b1;
      pulse_high_next  = 1'b0;
      tick_count_next  = '0;
      backing_off_next = 1'b0;
      if (dvd == '0) begin
        done_next = 1'b1;
      end else begin
        steps_left_next = dvd;
        busy_flag_next  = 1'b1;
      end
    end
  end

  // Hold motion state
  always_ff @(posedge clk) begin
    if (rst) begin
      busy_flag   <= 1'b0;
      backing_off <= 1'b0;
      direction   <= 1'b0;
      steps_left  <= '0;
      tick_count  <= '0;
      pulse_high  <= 1'b0;
    end else begin
      busy_flag   <= busy_flag_next;
      backing_off <= backing_off_next;
      direction   <= direction_next;
      steps_left  <= steps_left_next;
      tick_count  <= tick_count_next;
      pulse_high  <= pulse_high_next;
    end
  end

  // Output register: load a result, drop it once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_wr) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_wr) begin
      out_step <= pulse_high_next;
      out_dir  <= direction_next ^ cfg.direction_invert;
      out_busy <= busy_flag_next;
      out_done <= done_next;
      out_hit  <= hit_next;
    end
  end

  always_comb begin
    m_tdata             = '0;
    m_tdata[M_STEP_BIT] = out_step;
    m_tdata[M_DIR_BIT]  = out_dir;
    m_tdata[M_BUSY_BIT] = out_busy;
    m_tdata[M_HIT_BIT]  = out_hit;
  end
  assign m_tlast = out_done;

  // A commit never finds an unread result
  a_commit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> !m_tvalid)
    else $error("commit over a pending result");

  // Endstop hit only reported with done, and done only on an idle axis
  a_hit_done: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && out_hit |-> out_done && !out_busy)
    else $error("endstop hit without completed move");

  // No pulse and no back-off outside a move
  a_idle_quiet: assert property (@(posedge clk) disable iff (rst)
    !busy_flag |-> !pulse_high && !backing_off)
    else $error("pulse or back-off while idle");

endmodule

// File: sv/stepper_move_with_endstop_backoff.sv
// ----------------------------------------------------------------------------
// stepper_move_with_endstop_backoff
// Single-axis step/direction generator with endstop back-off, stream input
// and output, APB configuration.
// ----------------------------------------------------------------------------
// Results: a tick or a start on a busy axis gives its result in the cycle after
//   acceptance; a start on an idle axis first runs the restoring divider, which
//   produces one quotient bit a cycle, and then commits the move.
// Throughput: one item in flight; next item taken as the result leaves.
// Reset: synchronous, clears motion state and loads register reset values.
module stepper_move_with_endstop_backoff #(
  parameter int ANGLE_BITS = 20
) (
  input  logic                           clk,
  input  logic                           rst,
  // s_tdata: angle [19:0], endstop [20], zero [23:21]
  input  logic [smeb_pkg::S_TDATA_W-1:0] s_tdata,
  // s_tuser: operation [0]
  input  logic                           s_tuser,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // m_tdata: step_pin [0], dir_pin [1], busy_res [2], endstop_hit [3], zero [7:4]
  output logic [smeb_pkg::M_TDATA_W-1:0] m_tdata,
  // m_tlast: done_res
  output logic                           m_tlast,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [smeb_pkg::PADDR_W-1:0]   paddr,
  input  logic [smeb_pkg::PDATA_W-1:0]   pwdata,
  output logic [smeb_pkg::PDATA_W-1:0]   prdata,
  output logic                           pready
);
  import smeb_pkg::*;

  cfg_t cfg;
  cmd_t cmd;
  sts_t sts;

  smeb_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  smeb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .op       (s_tuser),
    .sts      (sts),
    .cmd      (cmd)
  );

  smeb_dp #(
    .ANGLE_BITS (ANGLE_BITS)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .sts      (sts),
    .cfg      (cfg),
    .angle    (s_tdata[ANGLE_W-1:0]),
    .endstop  (s_tdata[S_ENDSTOP_BIT]),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

endmodule

// File: test/tb_stepper_move_with_endstop_backoff.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_stepper_move_with_endstop_backoff
// Self-checking bench for the step/direction generator. Each accepted item is
// run through a local model of the axis, and the predicted pin levels are
// queued. Every result item is compared field by field with the oldest
// prediction. Directed moves cover the corner cases. Random well-formed moves
// with random endstop presses then run under several register settings.
// ----------------------------------------------------------------------------
module tb_stepper_move_with_endstop_backoff;
  import smeb_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int TAIL_CYCLES    = 30;
  localparam int RANDOM_ITEMS   = 1200;
  localparam int IDLE_PERCENT   = 18;

  typedef struct packed {
    logic step;
    logic dir;
    logic busy;
    logic done;
    logic hit;
  } axis_levels_t;

  logic                 clk      = 1'b0;
  logic                 rst      = 1'b1;
  logic [S_TDATA_W-1:0] s_tdata  = '0;
  logic                 s_tuser  = OP_START;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [M_TDATA_W-1:0] m_tdata;
  logic                 m_tlast;
  logic                 m_tvalid;
  logic                 m_tready = 1'b1;
  logic                 psel     = 1'b0;
  logic                 penable  = 1'b0;
  logic                 pwrite   = 1'b0;
  logic [PADDR_W-1:0]   paddr    = '0;
  logic [PDATA_W-1:0]   pwdata   = '0;
  logic [PDATA_W-1:0]   prdata;
  logic                 pready;

  // Register copies used for prediction
  logic [CFG_W-1:0] cfg_step_angle    = RST_STEP_ANGLE;
  logic [CFG_W-1:0] cfg_backoff_steps = RST_BACKOFF_STEPS;
  logic [CFG_W-1:0] cfg_half_period   = RST_HALF_PERIOD;
  logic             cfg_dir_invert    = RST_DIR_INVERT;

  // Predicted axis state
  logic               ax_busy    = 1'b0;
  logic               ax_backoff = 1'b0;
  logic               ax_dir     = 1'b0;
  logic [ANGLE_W-1:0] ax_steps   = '0;
  logic [CFG_W-1:0]   ax_ticks   = '0;
  logic               ax_pulse   = 1'b0;

  axis_levels_t pin_levels_due[$];

  bit idling = 1'b1;
  int mismatches;
  int results_seen;
  int items_sent;
  int moves_done;
  int backoff_ends;
  int reg_writes;
  int idle_cycles;

  stepper_move_with_endstop_backoff #(
    .ANGLE_BITS(ANGLE_W)
  ) DUT (
    .clk     (clk),
    .rst     (rst),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .m_tdata (m_tdata),
    .m_tlast (m_tlast),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // 20 ns clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Stall the result side at random while idling is enabled
  always @(negedge clk) begin
    m_tready = !idling || ($urandom_range(99) >= IDLE_PERCENT);
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("MISMATCH %s at result %0d: got %0h, want %0h", what, results_seen, got, want);
    mismatches++;
  endtask

  // Advance the axis by one item and return the pin levels it leaves behind
  task automatic predict_axis_levels(input logic op, input logic [ANGLE_W-1:0] angle,
                                     input logic endstop, output axis_levels_t lv);
    logic               done;
    logic               hit;
    logic               step_complete;
    logic               finish;
    logic [CFG_W-1:0]   divisor;
    logic [CFG_W-1:0]   phase_last;
    logic [ANGLE_W-1:0] count;
    done = 1'b0;
    hit = 1'b0;
    step_complete = 1'b0;
    finish = 1'b0;
    phase_last = (cfg_half_period == 0) ? '0 : cfg_half_period - CFG_W'(1);
    if (op == OP_START) begin
      if (!ax_busy) begin
        divisor = (cfg_step_angle == 0) ? 16'd1 : cfg_step_angle;
        count = angle / ANGLE_W'(divisor);
        ax_pulse = 1'b0;
        ax_ticks = '0;
        ax_backoff = 1'b0;
        if (count == 0) begin
          done = 1'b1;
        end else begin
          ax_steps = count;
          ax_busy = 1'b1;
        end
      end
    end else if (ax_busy) begin
      if (!ax_pulse && ax_ticks == 0) begin
        // start of a step: sample the endstop unless already backing off
        if (!ax_backoff && endstop) begin
          ax_backoff = 1'b1;
          ax_dir = ~ax_dir;
          ax_steps = ANGLE_W'(cfg_backoff_steps);
          finish = (cfg_backoff_steps == 0);
        end
        if (finish) begin
          ax_busy = 1'b0;
          done = 1'b1;
          hit = 1'b1;
          ax_backoff = 1'b0;
        end else begin
          ax_pulse = 1'b1;
          ax_ticks = phase_last;
        end
      end else if (ax_pulse) begin
        if (ax_ticks > 0) begin
          ax_ticks = ax_ticks - CFG_W'(1);
        end else begin
          ax_pulse = 1'b0;
          ax_ticks = phase_last;
          step_complete = (ax_ticks == 0);
        end
      end else begin
        ax_ticks = ax_ticks - CFG_W'(1);
        step_complete = (ax_ticks == 0);
      end
      if (step_complete) begin
        ax_steps = ax_steps - ANGLE_W'(1);
        if (ax_steps == 0) begin
          ax_busy = 1'b0;
          done = 1'b1;
          hit = ax_backoff;
          ax_backoff = 1'b0;
        end
      end
    end
    lv = '{ax_pulse, ax_dir ^ cfg_dir_invert, ax_busy, done, hit};
  endtask

  // Offer one item, hold it until taken, then queue its predicted levels
  task automatic send_item(input logic op, input logic [ANGLE_W-1:0] angle,
                           input logic endstop);
    axis_levels_t lv;
    @(negedge clk);
    while (idling && $urandom_range(99) < IDLE_PERCENT) begin
      s_tvalid = 1'b0;
      @(negedge clk);
    end
    s_tdata = {3'b000, endstop, angle};
    s_tuser = op;
    s_tvalid = 1'b1;
    do @(posedge clk); while (!s_tready);
    predict_axis_levels(op, angle, endstop, lv);
    pin_levels_due.push_back(lv);
    items_sent++;
    if (lv.done) moves_done++;
    if (lv.hit) backoff_ends++;
  endtask

  // Drop valid and wait for every predicted result to arrive
  task automatic drain();
    @(negedge clk);
    s_tvalid = 1'b0;
    while (pin_levels_due.size() != 0) @(posedge clk);
  endtask

  // Tick without endstop until the current move has ended
  task automatic finish_move();
    while (ax_busy) send_item(OP_TICK, ANGLE_W'($urandom_range(0, 20'hFFFFF)), 1'b0);
  endtask

  task automatic read_register(input logic [1:0] idx, input logic [CFG_W-1:0] want);
    logic [PDATA_W-1:0] mask;
    mask = (idx == REG_DIR_INVERT) ? 32'h1 : 32'hFFFF;
    @(negedge clk);
    s_tvalid = 1'b0;
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = {idx, 2'b00};
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    if ((prdata & mask) != (PDATA_W'(want) & mask))
      report_mismatch("register read", prdata & mask, PDATA_W'(want) & mask);
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
  endtask

  // Write one register, mirror it in the local copy, then read it back
  task automatic set_register(input logic [1:0] idx, input logic [CFG_W-1:0] value);
    @(negedge clk);
    s_tvalid = 1'b0;
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = {idx, 2'b00};
    pwdata = PDATA_W'(value);
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_STEP_ANGLE:    cfg_step_angle = value;
      REG_BACKOFF_STEPS: cfg_backoff_steps = value;
      REG_HALF_PERIOD:   cfg_half_period = value;
      default:           cfg_dir_invert = value[0];
    endcase
    reg_writes++;
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    read_register(idx, value);
  endtask

  // Check each result item against the oldest prediction
  always @(posedge clk) begin : check_results
    axis_levels_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pin_levels_due.size() == 0) begin
        report_mismatch("unexpected result", 32'({m_tlast, m_tdata}), '0);
      end else begin
        want = pin_levels_due.pop_front();
        if (m_tdata[M_STEP_BIT] !== want.step)
          report_mismatch("step_pin", 32'(m_tdata[M_STEP_BIT]), 32'(want.step));
        if (m_tdata[M_DIR_BIT] !== want.dir)
          report_mismatch("dir_pin", 32'(m_tdata[M_DIR_BIT]), 32'(want.dir));
        if (m_tdata[M_BUSY_BIT] !== want.busy)
          report_mismatch("busy_res", 32'(m_tdata[M_BUSY_BIT]), 32'(want.busy));
        if (m_tlast !== want.done)
          report_mismatch("done_res", 32'(m_tlast), 32'(want.done));
        if (m_tdata[M_HIT_BIT] !== want.hit)
          report_mismatch("endstop_hit", 32'(m_tdata[M_HIT_BIT]), 32'(want.hit));
        if (m_tdata[M_TDATA_W-1:4] !== '0)
          report_mismatch("padding bits", 32'(m_tdata[M_TDATA_W-1:4]), '0);
      end
      results_seen++;
    end
  end

  // End the run when no handshake has happened for too long
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
        $display("FAILED: results differ");
        $finish;
      end
    end
  end

  task automatic test_register_defaults();
    read_register(REG_STEP_ANGLE, RST_STEP_ANGLE);
    read_register(REG_BACKOFF_STEPS, RST_BACKOFF_STEPS);
    read_register(REG_HALF_PERIOD, RST_HALF_PERIOD);
    read_register(REG_DIR_INVERT, 16'(RST_DIR_INVERT));
  endtask

  // Ticks on an idle axis, and starts too short for one step
  task automatic test_idle_and_zero_step();
    send_item(OP_TICK, 20'h00000, 1'b1);
    send_item(OP_TICK, 20'hFFFFF, 1'b0);
    send_item(OP_START, 20'h00000, 1'b0);
    send_item(OP_START, 20'd460, 1'b1);
  endtask

  // Two-step move with a start arriving in the middle
  task automatic test_busy_start_ignored();
    send_item(OP_START, 20'd922, 1'b0);
    send_item(OP_TICK, 20'h00000, 1'b0);
    send_item(OP_START, 20'hFFFFF, 1'b0);
    finish_move();
  endtask

  // Endstop pressed at a step start; further presses during back-off ignored
  task automatic test_endstop_backoff();
    drain();
    set_register(REG_BACKOFF_STEPS, 16'd2);
    send_item(OP_START, 20'd1383, 1'b0);
    send_item(OP_TICK, 20'h00000, 1'b0);
    send_item(OP_TICK, 20'h00000, 1'b0);
    send_item(OP_TICK, 20'h00000, 1'b1);
    while (ax_busy) send_item(OP_TICK, 20'h00000, 1'b1);
  endtask

  // Back-off count of zero ends the move on the press itself
  task automatic test_zero_backoff();
    drain();
    set_register(REG_BACKOFF_STEPS, 16'd0);
    send_item(OP_START, 20'd2765, 1'b0);
    send_item(OP_TICK, 20'h00000, 1'b1);
  endtask

  // Zero step angle and half period count as one; direction pin inverted
  task automatic test_zero_registers();
    drain();
    set_register(REG_STEP_ANGLE, 16'd0);
    set_register(REG_HALF_PERIOD, 16'd0);
    set_register(REG_DIR_INVERT, 16'd1);
    send_item(OP_START, 20'd2, 1'b0);
    finish_move();
  endtask

  // Random moves under a fresh register setting per phase
  task automatic test_random_moves();
    int          phase;
    int          first_item;
    int unsigned divisor;
    int unsigned steps;
    longint      angle;
    logic [CFG_W-1:0] sa;
    phase = 0;
    first_item = items_sent;
    while (items_sent - first_item < RANDOM_ITEMS) begin
      finish_move();
      drain();
      // phases four to six run without any idling
      idling = (phase < 4 || phase > 6);
      case (phase % 4)
        1:       sa = 16'd1;
        2:       sa = 16'hFFFF;
        default: sa = CFG_W'($urandom_range(0, (1 << $urandom_range(1, 16)) - 1));
      endcase
      set_register(REG_STEP_ANGLE, sa);
      set_register(REG_BACKOFF_STEPS, CFG_W'($urandom_range(0, 5)));
      set_register(REG_HALF_PERIOD, CFG_W'($urandom_range(0, 3)));
      set_register(REG_DIR_INVERT, CFG_W'($urandom_range(0, 1)));
      divisor = (cfg_step_angle == 0) ? 1 : cfg_step_angle;
      repeat (100) begin
        if (ax_busy) begin
          if ($urandom_range(99) < 4)
            send_item(OP_START, ANGLE_W'($urandom_range(0, 20'hFFFFF)),
                      1'($urandom_range(0, 1)));
          else
            send_item(OP_TICK, ANGLE_W'($urandom_range(0, 20'hFFFFF)),
                      $urandom_range(99) < 8);
        end else begin
          case ($urandom_range(99) / 10)
            8: send_item(OP_TICK, ANGLE_W'($urandom_range(0, 20'hFFFFF)),
                         1'($urandom_range(0, 1)));
            9: send_item(OP_START, ANGLE_W'($urandom_range(0, divisor - 1)),
                         1'($urandom_range(0, 1)));
            default: begin
              // well-formed move: mostly short, sometimes up to sixteen steps
              steps = ($urandom_range(99) < 20) ? $urandom_range(1, 16) : $urandom_range(1, 4);
              angle = longint'(steps) * divisor + $urandom_range(0, divisor - 1);
              if (angle > 20'hFFFFF)
                angle = longint'(20'hFFFFF) - longint'($urandom_range(0, divisor - 1));
              send_item(OP_START, angle[ANGLE_W-1:0], 1'($urandom_range(0, 1)));
            end
          endcase
        end
      end
      phase++;
    end
    idling = 1'b1;
  endtask

  // Largest register values; the move is left running at the end
  task automatic test_extreme_registers();
    finish_move();
    drain();
    set_register(REG_STEP_ANGLE, 16'hFFFF);
    set_register(REG_BACKOFF_STEPS, 16'hFFFF);
    set_register(REG_HALF_PERIOD, 16'hFFFF);
    set_register(REG_DIR_INVERT, 16'd0);
    send_item(OP_START, 20'hFFFFF, 1'b0);
    send_item(OP_TICK, 20'h00000, 1'b1);
    repeat (20) send_item(OP_TICK, ANGLE_W'($urandom_range(0, 20'hFFFFF)),
                          1'($urandom_range(0, 1)));
    send_item(OP_START, 20'h00000, 1'b0);
  endtask

  initial begin
    repeat (9) @(negedge clk);
    rst = 1'b0;
    test_register_defaults();
    test_idle_and_zero_step();
    test_busy_start_ignored();
    test_endstop_backoff();
    test_zero_backoff();
    test_zero_registers();
    test_random_moves();
    test_extreme_registers();
    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Run covered %0d items and %0d results, %0d register writes.",
             items_sent, results_seen, reg_writes);
    $display("Moves completed: %0d, of which %0d ended after endstop back-off.",
             moves_done, backoff_ends);
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
